// ===== rtl/ppbc_pkg.sv =====
// ----------------------------------------------------------------------------
// ppbc_pkg
// Shared types, constants and the divider step for the projection/cull block.
// ----------------------------------------------------------------------------
package ppbc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = 248;
    localparam int OUT_DATA_W = 72;
    localparam int NUM_W      = 63;   // |scale*coord| <= 2^62
    localparam int DIV_STEPS  = NUM_W;
    localparam int QDEPTH     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_X_SCALE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PROJECT_ALL = 3'd4;

    localparam logic CMD_VERTEX  = 1'b0;
    localparam logic CMD_POLYGON = 1'b1;

    localparam logic [7:0] BIT_FRONT  = 8'h80;
    localparam logic [7:0] BIT_KEEP   = 8'h10;
    localparam logic [7:0] BIT_MARK   = 8'h40;
    localparam logic [7:0] KEEP_LOW7  = 8'h7F;
    localparam logic [7:0] AUX_NOCULL = 8'h04;

    localparam logic [31:0] SCALE_RESET = 32'h0001_0000;

    // one queued beat between the front and the back
    typedef struct packed {
        logic             proj;
        logic [NUM_W-1:0] num_x;
        logic [NUM_W-1:0] num_y;
        logic             neg_x;
        logic             neg_y;
        logic [31:0]      den;
        logic [7:0]       new_flags;
        logic             last;
    } ppbc_entry_t;

    typedef struct packed {
        logic [31:0]      rem;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] quo;
        logic             neg;
    } ppbc_lane_t;

    typedef struct packed {
        ppbc_lane_t  lx;
        ppbc_lane_t  ly;
        logic [31:0] den;
        logic        proj;
        logic [7:0]  new_flags;
        logic        last;
    } ppbc_stage_t;

    // one restoring division step: bring down the next dividend bit
    function automatic ppbc_lane_t ppbc_div_step(input ppbc_lane_t l, input logic [31:0] den);
        ppbc_lane_t  r;
        logic [32:0] t;
        logic        ge;
        t     = {l.rem, l.num[NUM_W-1]};
        ge    = (t >= {1'b0, den});
        r.rem = ge ? 32'(t - {1'b0, den}) : t[31:0];
        r.num = {l.num[NUM_W-2:0], 1'b0};
        r.quo = {l.quo[NUM_W-2:0], ge};
        r.neg = l.neg;
        return r;
    endfunction

endpackage

// ===== rtl/ppbc_front.sv =====
// ----------------------------------------------------------------------------
// ppbc_front
// Accept beats, multiply, run the area test and build queue entries.
// ----------------------------------------------------------------------------
module ppbc_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_cmd,
    input  logic [ppbc_pkg::IN_DATA_W-1:0] in_data,
    input  logic                          in_last,
    input  logic [31:0]                   x_scale,
    input  logic [31:0]                   y_scale,
    input  logic                          project_all,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ppbc_pkg::ppbc_entry_t         out_entry
);
    import ppbc_pkg::*;

    logic [7:0]  flags, aux;
    logic        present;
    logic [31:0] x0, y0, z0, x1, y1, x2, y2;
    assign flags   = in_data[7:0];
    assign aux     = in_data[15:8];
    assign present = in_data[16];
    assign x0      = in_data[48:17];
    assign y0      = in_data[80:49];
    assign z0      = in_data[112:81];
    assign x1      = in_data[144:113];
    assign y1      = in_data[176:145];
    assign x2      = in_data[208:177];
    assign y2      = in_data[240:209];

    // stage A: products
    logic               a_v_reg;
    logic               a_proj_reg, a_cmd_reg, a_present_reg, a_last_reg;
    logic [7:0]         a_flags_reg, a_aux_reg;
    logic signed [63:0] a_px_reg, a_py_reg;
    logic [31:0]        a_z_reg;
    logic signed [65:0] a_l_reg, a_r_reg;
    // stage B: entry
    logic               b_v_reg;
    ppbc_entry_t        b_entry_reg;
    ppbc_entry_t        entry_next;
    logic [63:0]        abs_x, abs_y;

    logic a_ready, b_ready;
    assign b_ready  = !b_v_reg || out_ready;
    assign a_ready  = !a_v_reg || b_ready;
    assign in_ready = a_ready;

    logic signed [32:0] d_ac_x, d_ab_y, d_ab_x, d_ac_y;
    logic               proj_in;
    assign d_ac_x  = $signed({x0[31], x0}) - $signed({x2[31], x2});
    assign d_ab_y  = $signed({y0[31], y0}) - $signed({y1[31], y1});
    assign d_ab_x  = $signed({x0[31], x0}) - $signed({x1[31], x1});
    assign d_ac_y  = $signed({y0[31], y0}) - $signed({y2[31], y2});
    assign proj_in = (in_cmd == CMD_VERTEX) && (project_all || ((flags & BIT_FRONT) != 8'h0))
                     && (z0 != 32'h0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_v_reg <= in_valid;
            if (b_ready)
                b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_proj_reg    <= proj_in;
            a_cmd_reg     <= in_cmd;
            a_present_reg <= present;
            a_last_reg    <= in_last;
            a_flags_reg   <= flags;
            a_aux_reg     <= aux;
            a_px_reg      <= $signed(x_scale) * $signed(x0);
            a_py_reg      <= $signed(y_scale) * $signed(y0);
            a_z_reg       <= z0;
            a_l_reg       <= d_ac_x * d_ab_y;
            a_r_reg       <= d_ab_x * d_ac_y;
        end
        if (b_ready && a_v_reg)
            b_entry_reg <= entry_next;
    end

    always_comb
    begin
        abs_x = a_px_reg[63] ? 64'(-a_px_reg) : 64'(a_px_reg);
        abs_y = a_py_reg[63] ? 64'(-a_py_reg) : 64'(a_py_reg);
        entry_next.proj  = a_proj_reg;
        entry_next.num_x = abs_x[NUM_W-1:0];
        entry_next.num_y = abs_y[NUM_W-1:0];
        entry_next.neg_x = a_px_reg[63] ^ a_z_reg[31];
        entry_next.neg_y = a_py_reg[63] ^ a_z_reg[31];
        // keep a harmless divisor when the vertex is not projected
        if (a_proj_reg)
            entry_next.den = a_z_reg[31] ? 32'(-a_z_reg) : a_z_reg;
        else
            entry_next.den = 32'd1;
        entry_next.new_flags = a_flags_reg;
        if ((a_cmd_reg == CMD_POLYGON) && ((a_flags_reg & BIT_FRONT) != 8'h0))
        begin
            if ((a_flags_reg & BIT_KEEP) != 8'h0)
                entry_next.new_flags = a_flags_reg | BIT_MARK;
            else if (a_present_reg && (a_l_reg > a_r_reg) && ((a_aux_reg & AUX_NOCULL) == 8'h0))
                entry_next.new_flags = a_flags_reg & KEEP_LOW7;
        end
        entry_next.last = a_last_reg;
    end

    assign out_valid = b_v_reg;
    assign out_entry = b_entry_reg;

endmodule

// ===== rtl/ppbc_queue.sv =====
// ----------------------------------------------------------------------------
// ppbc_queue
// Short FIFO between front and back.
// ----------------------------------------------------------------------------
module ppbc_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_valid,
    output logic                  wr_ready,
    input  ppbc_pkg::ppbc_entry_t wr_entry,
    output logic                  rd_valid,
    input  logic                  rd_ready,
    output ppbc_pkg::ppbc_entry_t rd_entry
);
    import ppbc_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);

    ppbc_entry_t      mem_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             push, pop;

    assign wr_ready = (count_reg != (PTR_W+1)'(QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_entry = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= PTR_W'((wr_ptr_reg + 1'b1) % QDEPTH);
            if (pop)
                rd_ptr_reg <= PTR_W'((rd_ptr_reg + 1'b1) % QDEPTH);
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

// ===== rtl/ppbc_back.sv =====
// ----------------------------------------------------------------------------
// ppbc_back
// Pipelined divide by z, sign, offset, saturate and output register.
// ----------------------------------------------------------------------------
module ppbc_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ppbc_pkg::ppbc_entry_t in_entry,
    input  logic [31:0]           x_offset,
    input  logic [31:0]           y_offset,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [ppbc_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);
    import ppbc_pkg::*;

    logic        en;
    assign en       = !m_tvalid || m_tready;
    assign in_ready = en;

    ppbc_stage_t st_reg [DIV_STEPS+1];
    logic [DIV_STEPS:0] v_reg;
    ppbc_stage_t st_in;

    always_comb
    begin
        st_in.lx.rem   = '0;
        st_in.lx.num   = in_entry.num_x;
        st_in.lx.quo   = '0;
        st_in.lx.neg   = in_entry.neg_x;
        st_in.ly.rem   = '0;
        st_in.ly.num   = in_entry.num_y;
        st_in.ly.quo   = '0;
        st_in.ly.neg   = in_entry.neg_y;
        st_in.den      = in_entry.den;
        st_in.proj     = in_entry.proj;
        st_in.new_flags = in_entry.new_flags;
        st_in.last     = in_entry.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[DIV_STEPS-1:0], in_valid};
    end

    // load the input stage and advance each divider stage by one quotient bit while en is high
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= st_in;
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                st_reg[i+1].lx        <= ppbc_div_step(st_reg[i].lx, st_reg[i].den);
                st_reg[i+1].ly        <= ppbc_div_step(st_reg[i].ly, st_reg[i].den);
                st_reg[i+1].den       <= st_reg[i].den;
                st_reg[i+1].proj      <= st_reg[i].proj;
                st_reg[i+1].new_flags <= st_reg[i].new_flags;
                st_reg[i+1].last      <= st_reg[i].last;
            end
        end
    end

    function automatic logic [31:0] finish(input ppbc_lane_t l, input logic [31:0] off);
        logic signed [63:0] q;
        logic signed [64:0] s;
        q = l.neg ? -$signed({1'b0, l.quo}) : $signed({1'b0, l.quo});
        s = $signed({q[63], q}) + $signed({{33{off[31]}}, off});
        if (s > 65'sd2147483647)
            return 32'h7FFF_FFFF;
        else if (s < -65'sd2147483648)
            return 32'h8000_0000;
        else
            return s[31:0];
    endfunction

    ppbc_stage_t last_st;
    logic [31:0] sx_next, sy_next;
    assign last_st = st_reg[DIV_STEPS];
    assign sx_next = last_st.proj ? finish(last_st.lx, x_offset) : 32'h0;
    assign sy_next = last_st.proj ? finish(last_st.ly, y_offset) : 32'h0;

    logic                  out_v_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_user_reg, out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= v_reg[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {last_st.new_flags, sy_next, sx_next};
            out_user_reg <= last_st.proj;
            out_last_reg <= last_st.last;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/perspective_project_backface_cull.sv =====
// ----------------------------------------------------------------------------
// perspective_project_backface_cull
// Vertex perspective projection and polygon back-face cull, one beat a cycle.
// ----------------------------------------------------------------------------
// Takes one beat per clock and returns one result beat for every input beat,
// in order. Vertex beats (s_tuser = 0) are projected to screen = scale*coord/z
// + offset in signed Q16.16 with saturation; polygon beats (s_tuser = 1) get
// their flag byte updated by the signed-area back-face test. A beat passes
// the front stages (multiply, area compare), the 2-entry queue, the divider
// pipeline (an input stage, then 63 stages of one quotient bit each) and the
// output register, with a new beat accepted every cycle while m_tready stays
// high. The front and back stall independently, the queue absorbing the
// difference. Configuration writes are always taken; change registers only
// while no beat is in flight.
// ----------------------------------------------------------------------------
module perspective_project_backface_cull
(
    input  logic                                clk,
    input  logic                                rst_n,
    // input beats
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // flags[7:0] aux_flags[15:8] verts_present[16] x0[48:17] y0[80:49]
    // z0[112:81] x1[144:113] y1[176:145] x2[208:177] y2[240:209], zero pad
    input  logic [ppbc_pkg::IN_DATA_W-1:0]      s_tdata,
    // cmd[0]
    input  logic                                s_tuser,
    input  logic                                s_tlast,
    // result beats
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // screen_x[31:0] screen_y[63:32] new_flags[71:64]
    output logic [ppbc_pkg::OUT_DATA_W-1:0]     m_tdata,
    // projected[0]
    output logic                                m_tuser,
    output logic                                m_tlast,
    // register writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ppbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                         cfg_data
);
    import ppbc_pkg::*;

    logic [31:0] x_scale_reg, y_scale_reg, x_offset_reg, y_offset_reg;
    logic        project_all_reg;

    assign cfg_ready = 1'b1;

    // register file; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_scale_reg     <= SCALE_RESET;
            y_scale_reg     <= SCALE_RESET;
            x_offset_reg    <= '0;
            y_offset_reg    <= '0;
            project_all_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_X_SCALE:     x_scale_reg     <= cfg_data;
                REG_Y_SCALE:     y_scale_reg     <= cfg_data;
                REG_X_OFFSET:    x_offset_reg    <= cfg_data;
                REG_Y_OFFSET:    y_offset_reg    <= cfg_data;
                REG_PROJECT_ALL: project_all_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    logic        f_valid, f_ready, q_valid, q_ready;
    ppbc_entry_t f_entry, q_entry;

    ppbc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (s_tuser),
        .in_data     (s_tdata),
        .in_last     (s_tlast),
        .x_scale     (x_scale_reg),
        .y_scale     (y_scale_reg),
        .project_all (project_all_reg),
        .out_valid   (f_valid),
        .out_ready   (f_ready),
        .out_entry   (f_entry)
    );

    ppbc_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_entry (f_entry),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_entry (q_entry)
    );

    ppbc_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_entry (q_entry),
        .x_offset (x_offset_reg),
        .y_offset (y_offset_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
